/* rtl/rfm_pkg.sv */
// Shared types, widths and constants of the range fingerprint matcher.
package rfm_pkg;

  // Table geometry
  localparam int TABLE_DEPTH = 256;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int PTR_MIN_W   = $clog2(TABLE_DEPTH + 1);
  localparam int ACT_W       = 9;
  localparam int LIM_W       = (PTR_MIN_W > ACT_W) ? PTR_MIN_W : ACT_W;

  // Field widths
  localparam int ENTRY_IDX_W = 8;
  localparam int DIST_W      = 9;
  localparam int OFS_W       = 6;
  localparam int ADJ_W       = DIST_W + 1;
  localparam int WGT_W       = 8;
  localparam int CNT_W       = 9;
  localparam int ENTRY_W     = 4 * DIST_W;

  // Configuration port
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 9;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_POINTS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BACK_OFFSET   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_OFFSET   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_OFFSET  = 3'd4;

  // Register reset values
  localparam logic [ACT_W-1:0] RST_ACTIVE_POINTS = 9'd169;
  localparam logic [OFS_W-1:0] RST_TOLERANCE     = 6'd5;
  localparam logic [OFS_W-1:0] RST_BACK_OFFSET   = 6'd21;
  localparam logic [OFS_W-1:0] RST_LEFT_OFFSET   = 6'd7;
  localparam logic [OFS_W-1:0] RST_RIGHT_OFFSET  = 6'd7;

  // Operation codes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_SCAN = 1'b1;

  localparam logic [WGT_W-1:0] WGT_MAX = '1;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic capture;
    logic load_write;
    logic scan_issue;
  } ctrl_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic scan_end;
  } ctrl_sts_t;

  // Absolute difference of two unsigned distances.
  function automatic logic [ADJ_W-1:0] abs_diff(input logic [ADJ_W-1:0] a,
                                                input logic [ADJ_W-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

/* rtl/rfm_ram.sv */
// Generic simple dual-port RAM with a registered read port.
module rfm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* rtl/rfm_ctrl.sv */
// Controller state machine sequencing loads and table scans.
module rfm_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               in_operation,
  input  rfm_pkg::ctrl_sts_t sts,
  output rfm_pkg::ctrl_cmd_t cmd,
  output logic               busy,
  output logic               out_valid
);
  import rfm_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_LOAD   = 4'b0010,
    ST_SCAN   = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  assign accept = start && (state_r == ST_IDLE);

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = (in_operation == OP_SCAN) ? ST_SCAN : ST_LOAD;
        end
      end
      ST_LOAD: begin
        state_nxt = ST_FINISH;
      end
      ST_SCAN: begin
        if (sts.scan_end) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Commands to the datapath and handshake outputs.
  assign cmd.capture    = accept;
  assign cmd.load_write = (state_r == ST_LOAD);
  assign cmd.scan_issue = (state_r == ST_SCAN) && !sts.scan_end;
  assign busy           = (state_r != ST_IDLE);
  assign out_valid      = (state_r == ST_FINISH);

endmodule

/* rtl/rfm_datapath.sv */
// Datapath: configuration registers, table memories, comparators and counters.
module rfm_datapath (
  input  logic                           clk,
  input  logic                           rst_n,
  input  rfm_pkg::ctrl_cmd_t             cmd,
  output rfm_pkg::ctrl_sts_t             sts,
  input  logic [rfm_pkg::ENTRY_IDX_W-1:0] in_entry_index,
  input  logic [rfm_pkg::DIST_W-1:0]     in_front_dist,
  input  logic [rfm_pkg::DIST_W-1:0]     in_left_dist,
  input  logic [rfm_pkg::DIST_W-1:0]     in_back_dist,
  input  logic [rfm_pkg::DIST_W-1:0]     in_right_dist,
  input  logic                           cfg_we,
  input  logic [rfm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rfm_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic [rfm_pkg::CNT_W-1:0]      match_count,
  output logic [rfm_pkg::WGT_W-1:0]      best_weight
);
  import rfm_pkg::*;

  // Configuration registers
  logic [ACT_W-1:0] active_points_r;
  logic [OFS_W-1:0] tolerance_r, back_offset_r, left_offset_r, right_offset_r;

  // Captured item
  logic [ENTRY_IDX_W-1:0] idx_r;
  logic [DIST_W-1:0]      front_r, left_r, back_r, right_r;

  // Scan pointer, pipeline and accumulators
  logic [LIM_W-1:0]       ptr_r, ptr_nxt, scan_lim;
  logic                   rd_vld_r;
  logic [IDX_W-1:0]       rd_addr_r;
  logic                   rd_wvalid_r;
  logic [TABLE_DEPTH-1:0] wvalid_r;
  logic [CNT_W-1:0]       count_r;
  logic [WGT_W-1:0]       best_r;

  // Memory ports
  logic                   ref_we;
  logic [ENTRY_W-1:0]     ref_rdata;
  logic [WGT_W-1:0]       wgt_rdata;
  logic [IDX_W-1:0]       scan_addr;

  // Compare stage
  logic [ADJ_W-1:0]       m_front, m_left, m_back, m_right;
  logic [ADJ_W-1:0]       tol_ext;
  logic                   hit;
  logic [WGT_W-1:0]       w_cur, w_new;
  logic                   wgt_we;

  // Configuration writes; indexes outside the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_points_r <= RST_ACTIVE_POINTS;
      tolerance_r     <= RST_TOLERANCE;
      back_offset_r   <= RST_BACK_OFFSET;
      left_offset_r   <= RST_LEFT_OFFSET;
      right_offset_r  <= RST_RIGHT_OFFSET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ACTIVE_POINTS: active_points_r <= cfg_data[ACT_W-1:0];
        REG_TOLERANCE:     tolerance_r     <= cfg_data[OFS_W-1:0];
        REG_BACK_OFFSET:   back_offset_r   <= cfg_data[OFS_W-1:0];
        REG_LEFT_OFFSET:   left_offset_r   <= cfg_data[OFS_W-1:0];
        REG_RIGHT_OFFSET:  right_offset_r  <= cfg_data[OFS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Capture the input word when it is accepted.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      idx_r   <= in_entry_index;
      front_r <= in_front_dist;
      left_r  <= in_left_dist;
      back_r  <= in_back_dist;
      right_r <= in_right_dist;
    end
  end

  // Entries compared per scan, limited to the table depth.
  always_comb begin
    scan_lim = LIM_W'(active_points_r);
    if (scan_lim > LIM_W'(TABLE_DEPTH)) begin
      scan_lim = LIM_W'(TABLE_DEPTH);
    end
  end

  assign sts.scan_end = (ptr_r >= scan_lim);
  assign ptr_nxt      = cmd.capture ? '0 : (cmd.scan_issue ? ptr_r + 1'b1 : ptr_r);
  assign scan_addr    = ptr_r[IDX_W-1:0];

  // A load beyond the table is dropped.
  assign ref_we = cmd.load_write && ({1'b0, idx_r} < (ENTRY_IDX_W + 1)'(TABLE_DEPTH));

  // Reference table: front, left, back, right from high to low.
  rfm_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(TABLE_DEPTH)
  ) u_ref_ram (
    .clk   (clk),
    .we    (ref_we),
    .waddr (idx_r[IDX_W-1:0]),
    .wdata ({front_r, left_r, back_r, right_r}),
    .raddr (scan_addr),
    .rdata (ref_rdata)
  );

  // Entry weights; an entry without its valid bit reads as zero.
  rfm_ram #(
    .WIDTH(WGT_W),
    .DEPTH(TABLE_DEPTH)
  ) u_wgt_ram (
    .clk   (clk),
    .we    (wgt_we),
    .waddr (rd_addr_r),
    .wdata (w_new),
    .raddr (scan_addr),
    .rdata (wgt_rdata)
  );

  // Measured distances with the mounting offsets applied.
  assign m_front = ADJ_W'(front_r);
  assign m_left  = ADJ_W'(left_r) + ADJ_W'(left_offset_r);
  assign m_back  = ADJ_W'(back_r) + ADJ_W'(back_offset_r);
  assign m_right = ADJ_W'(right_r) + ADJ_W'(right_offset_r);
  assign tol_ext = ADJ_W'(tolerance_r);

  // An entry matches when every difference is strictly below the tolerance.
  assign hit = rd_vld_r
            && (abs_diff(m_front, ADJ_W'(ref_rdata[4*DIST_W-1:3*DIST_W])) < tol_ext)
            && (abs_diff(m_left,  ADJ_W'(ref_rdata[3*DIST_W-1:2*DIST_W])) < tol_ext)
            && (abs_diff(m_back,  ADJ_W'(ref_rdata[2*DIST_W-1:DIST_W]))   < tol_ext)
            && (abs_diff(m_right, ADJ_W'(ref_rdata[DIST_W-1:0]))          < tol_ext);

  // Saturating weight increment.
  assign w_cur  = rd_wvalid_r ? wgt_rdata : '0;
  assign w_new  = (w_cur == WGT_MAX) ? WGT_MAX : w_cur + 1'b1;
  assign wgt_we = hit;

  // Scan pointer and read pipeline.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      ptr_r    <= ptr_nxt;
      rd_vld_r <= cmd.scan_issue;
    end
  end

  always_ff @(posedge clk) begin
    rd_addr_r   <= scan_addr;
    rd_wvalid_r <= wvalid_r[scan_addr];
  end

  // Weight valid bits, match count and running best.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wvalid_r <= '0;
      count_r  <= '0;
      best_r   <= '0;
    end else begin
      if (cmd.capture) begin
        count_r <= '0;
      end else if (hit && (count_r != CNT_MAX)) begin
        count_r <= count_r + 1'b1;
      end
      if (hit) begin
        wvalid_r[rd_addr_r] <= 1'b1;
        if (w_new > best_r) begin
          best_r <= w_new;
        end
      end
    end
  end

  assign match_count = count_r;
  assign best_weight = best_r;

endmodule

/* rtl/range_fingerprint_matcher.sv */
// Top level of the range fingerprint matcher: controller plus datapath.
//
// Usage. An input word is taken at a rising edge with start high and busy low.
// in_operation selects a load (write one reference entry at in_entry_index with
// the four distances) or a scan (compare the four measured distances, with the
// configured offsets added to back, left and right, against the active entries).
// Every item gives one result word, shown for exactly one cycle with out_valid
// high: out_match_count (zero for a load) and out_best_weight.
// Sequence: a load writes its entry in the LOAD state and shows its result in the
// FINISH state; a scan reads the N active entries in the SCAN state and shows
// its result in FINISH. The next word can be taken in the cycle after the result.
// N is the active count limited to the table depth; the scan reads one
// table entry per cycle through the single read port of each table memory.
// Configuration words on the cfg_ channel are always taken (cfg_ready is high)
// and should only be written while the block is idle.
// Reset (rst_n low, synchronous) clears all weights, the running best and the
// registers to their defaults; reference entries hold nothing until loaded.
// The receiver cannot stall the result channel.
module range_fingerprint_matcher (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic                            in_operation,
  input  logic [rfm_pkg::ENTRY_IDX_W-1:0] in_entry_index,
  input  logic [rfm_pkg::DIST_W-1:0]      in_front_dist,
  input  logic [rfm_pkg::DIST_W-1:0]      in_left_dist,
  input  logic [rfm_pkg::DIST_W-1:0]      in_back_dist,
  input  logic [rfm_pkg::DIST_W-1:0]      in_right_dist,
  output logic                            out_valid,
  output logic [rfm_pkg::CNT_W-1:0]       out_match_count,
  output logic [rfm_pkg::WGT_W-1:0]       out_best_weight,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rfm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rfm_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import rfm_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  assign cfg_ready = 1'b1;

  // Sequencer.
  rfm_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .in_operation (in_operation),
    .sts          (sts),
    .cmd          (cmd),
    .busy         (busy),
    .out_valid    (out_valid)
  );

  // Tables, comparators and counters.
  rfm_datapath u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_entry_index (in_entry_index),
    .in_front_dist  (in_front_dist),
    .in_left_dist   (in_left_dist),
    .in_back_dist   (in_back_dist),
    .in_right_dist  (in_right_dist),
    .cfg_we         (cfg_valid && cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .match_count    (out_match_count),
    .best_weight    (out_best_weight)
  );

endmodule

/* verif/tb_range_fingerprint_matcher.sv */
// Self-checking testbench of the range fingerprint matcher: directed words, then random phases.
module tb_range_fingerprint_matcher;
  timeunit 1ns;
  timeprecision 1ps;

  import rfm_pkg::*;

  // Position of each distance within a word
  localparam int D_FRONT = 0;
  localparam int D_LEFT  = 1;
  localparam int D_BACK  = 2;
  localparam int D_RIGHT = 3;

  // Quiet cycles tolerated before the run is declared hung
  localparam int unsigned STALL_LIMIT = 4000;

  typedef struct packed {
    logic                          op;
    logic [ENTRY_IDX_W-1:0]        entry;
    logic [3:0][DIST_W-1:0]        ranges;
  } probe_word_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [WGT_W-1:0] best;
  } scan_result_t;

  // Mirror of the table, weights and registers, plus the words still owed by the block.
  class match_tracker;
    logic [3:0][DIST_W-1:0] points [TABLE_DEPTH];
    logic [WGT_W-1:0]       weights [TABLE_DEPTH];
    logic [WGT_W-1:0]       best;
    int unsigned            active, tol, ofs_back, ofs_left, ofs_right;
    scan_result_t           pending [$];
    int unsigned            failures;

    function new();
      foreach (weights[i]) weights[i] = '0;
      best      = '0;
      active    = RST_ACTIVE_POINTS;
      tol       = RST_TOLERANCE;
      ofs_back  = RST_BACK_OFFSET;
      ofs_left  = RST_LEFT_OFFSET;
      ofs_right = RST_RIGHT_OFFSET;
      failures  = 0;
    endfunction

    function void set_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
      case (idx)
        REG_ACTIVE_POINTS: active    = val[ACT_W-1:0];
        REG_TOLERANCE:     tol       = val[OFS_W-1:0];
        REG_BACK_OFFSET:   ofs_back  = val[OFS_W-1:0];
        REG_LEFT_OFFSET:   ofs_left  = val[OFS_W-1:0];
        REG_RIGHT_OFFSET:  ofs_right = val[OFS_W-1:0];
        default: ;
      endcase
    endfunction

    // Work out the result of an accepted word and queue it.
    function void note_item(input probe_word_t w);
      int unsigned  want [4];
      int unsigned  span, reach, hits, i, k;
      bit           hit;
      scan_result_t r;
      hits = 0;
      if (w.op == OP_LOAD) begin
        if (w.entry < TABLE_DEPTH) points[w.entry] = w.ranges;
      end else begin
        want[D_FRONT] = w.ranges[D_FRONT];
        want[D_LEFT]  = w.ranges[D_LEFT] + ofs_left;
        want[D_BACK]  = w.ranges[D_BACK] + ofs_back;
        want[D_RIGHT] = w.ranges[D_RIGHT] + ofs_right;
        reach = (active > TABLE_DEPTH) ? TABLE_DEPTH : active;
        for (i = 0; i < reach; i++) begin
          hit = 1'b1;
          for (k = 0; k < 4; k++) begin
            span = (want[k] > points[i][k]) ? want[k] - points[i][k] : points[i][k] - want[k];
            if (span >= tol) hit = 1'b0;
          end
          if (hit) begin
            if (weights[i] != WGT_MAX) weights[i] = weights[i] + 1'b1;
            if (weights[i] > best) best = weights[i];
            if (hits < CNT_MAX) hits++;
          end
        end
      end
      r.count = hits[CNT_W-1:0];
      r.best  = best;
      pending.push_back(r);
    endfunction

    // Compare a result word with the oldest one owed.
    function void check_result(input logic [CNT_W-1:0] cnt, input logic [WGT_W-1:0] bw);
      scan_result_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result word, count %0d best %0d", $time, cnt, bw);
        failures++;
        return;
      end
      e = pending.pop_front();
      if (cnt !== e.count) begin
        $display("%0t: match_count expected %0d actual %0d", $time, e.count, cnt);
        failures++;
      end
      if (bw !== e.best) begin
        $display("%0t: best_weight expected %0d actual %0d", $time, e.best, bw);
        failures++;
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   start = 1'b0;
  logic                   busy;
  logic                   in_operation = 1'b0;
  logic [ENTRY_IDX_W-1:0] in_entry_index = '0;
  logic [DIST_W-1:0]      in_front_dist = '0;
  logic [DIST_W-1:0]      in_left_dist = '0;
  logic [DIST_W-1:0]      in_back_dist = '0;
  logic [DIST_W-1:0]      in_right_dist = '0;
  logic                   out_valid;
  logic [CNT_W-1:0]       out_match_count;
  logic [WGT_W-1:0]       out_best_weight;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  match_tracker tracker;
  int unsigned  sender_gap_pct = 19;
  int unsigned  quiet_cycles = 0;

  range_fingerprint_matcher i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_operation    (in_operation),
    .in_entry_index  (in_entry_index),
    .in_front_dist   (in_front_dist),
    .in_left_dist    (in_left_dist),
    .in_back_dist    (in_back_dist),
    .in_right_dist   (in_right_dist),
    .out_valid       (out_valid),
    .out_match_count (out_match_count),
    .out_best_weight (out_best_weight),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Every result word is checked in the cycle it is shown.
  always @(posedge clk) begin
    if (rst_n && out_valid) tracker.check_result(out_match_count, out_best_weight);
  end

  // Hang detection: any accepted word or shown result word restarts the count.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("[range_fingerprint_matcher] ERROR");
      $finish;
    end
  end

  function automatic int wobble(input int unsigned amp);
    return int'($urandom_range(2 * amp)) - int'(amp);
  endfunction

  function automatic logic [DIST_W-1:0] clamp_dist(input int v);
    if (v < 0) return '0;
    if (v > (1 << DIST_W) - 1) return '1;
    return v[DIST_W-1:0];
  endfunction

  function automatic probe_word_t pack_item(input logic op, input int unsigned e,
                                            input int unsigned f, input int unsigned l,
                                            input int unsigned b, input int unsigned r);
    probe_word_t w;
    w.op               = op;
    w.entry            = e[ENTRY_IDX_W-1:0];
    w.ranges[D_FRONT]  = f[DIST_W-1:0];
    w.ranges[D_LEFT]   = l[DIST_W-1:0];
    w.ranges[D_BACK]   = b[DIST_W-1:0];
    w.ranges[D_RIGHT]  = r[DIST_W-1:0];
    return w;
  endfunction

  // A scan aimed at a reference point, with the offsets taken back off.
  function automatic probe_word_t scan_at(input logic [3:0][DIST_W-1:0] pt,
                                          input int unsigned jit);
    probe_word_t w;
    w.op              = OP_SCAN;
    w.entry           = ENTRY_IDX_W'($urandom_range(255));
    w.ranges[D_FRONT] = clamp_dist(int'(pt[D_FRONT]) + wobble(jit));
    w.ranges[D_LEFT]  = clamp_dist(int'(pt[D_LEFT]) - int'(tracker.ofs_left) + wobble(jit));
    w.ranges[D_BACK]  = clamp_dist(int'(pt[D_BACK]) - int'(tracker.ofs_back) + wobble(jit));
    w.ranges[D_RIGHT] = clamp_dist(int'(pt[D_RIGHT]) - int'(tracker.ofs_right) + wobble(jit));
    return w;
  endfunction

  // Offer one input word, idling first at random, and return at the edge that takes it.
  task automatic send_item(input probe_word_t w);
    while ($urandom_range(99) < sender_gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start          <= 1'b1;
    in_operation   <= w.op;
    in_entry_index <= w.entry;
    in_front_dist  <= w.ranges[D_FRONT];
    in_left_dist   <= w.ranges[D_LEFT];
    in_back_dist   <= w.ranges[D_BACK];
    in_right_dist  <= w.ranges[D_RIGHT];
    @(posedge clk);
    while (busy) @(posedge clk);
    tracker.note_item(w);
  endtask

  // Stop sending and wait until every owed result word has come back.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (tracker.pending.size() != 0) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Write all five registers once the block has gone idle.
  task automatic configure(input int unsigned act, input int unsigned tl,
                           input int unsigned bk, input int unsigned lf,
                           input int unsigned rt);
    logic [CFG_IDX_W-1:0] regs [5];
    int unsigned          vals [5];
    int unsigned          n;
    regs = '{REG_ACTIVE_POINTS, REG_TOLERANCE, REG_BACK_OFFSET, REG_LEFT_OFFSET,
             REG_RIGHT_OFFSET};
    vals = '{act, tl, bk, lf, rt};
    drain();
    repeat (4) @(posedge clk);
    for (n = 0; n < 5; n++) begin
      cfg_valid <= 1'b1;
      cfg_index <= regs[n];
      cfg_data  <= vals[n][CFG_DATA_W-1:0];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      tracker.set_reg(regs[n], vals[n]);
    end
    cfg_valid <= 1'b0;
  endtask

  // Load every active entry around one centre, then scan right on that centre.
  task automatic fill_table(input int unsigned spread);
    logic [3:0][DIST_W-1:0] centre;
    probe_word_t            w;
    int unsigned            reach, e, k;
    reach = (tracker.active > TABLE_DEPTH) ? TABLE_DEPTH : tracker.active;
    for (k = 0; k < 4; k++) centre[k] = DIST_W'($urandom_range(447, 64));
    for (e = 0; e < reach; e++) begin
      w.op    = OP_LOAD;
      w.entry = ENTRY_IDX_W'(e);
      for (k = 0; k < 4; k++) w.ranges[k] = clamp_dist(int'(centre[k]) + wobble(spread));
      send_item(w);
    end
    send_item(scan_at(centre, 0));
  endtask

  // Mostly scans aimed near loaded entries, some reloads and some arbitrary words.
  task automatic random_phase(input int unsigned items, input int unsigned load_pct,
                              input int unsigned junk_pct, input int unsigned jit);
    probe_word_t w;
    int unsigned reach, c, j, pick, k;
    reach = (tracker.active > TABLE_DEPTH) ? TABLE_DEPTH : tracker.active;
    for (c = 0; c < items; c++) begin
      if ($urandom_range(49) == 0) drain();
      pick = $urandom_range(99);
      j    = $urandom_range(reach - 1);
      if (pick < load_pct) begin
        w.op    = OP_LOAD;
        w.entry = $urandom_range(1) ? ENTRY_IDX_W'($urandom_range(255)) : ENTRY_IDX_W'(j);
        for (k = 0; k < 4; k++) begin
          w.ranges[k] = ($urandom_range(9) < 7) ?
                        clamp_dist(int'(tracker.points[j][k]) + wobble(jit)) :
                        DIST_W'($urandom_range(511));
        end
      end else if (pick < 100 - junk_pct) begin
        w = scan_at(tracker.points[j], jit);
      end else begin
        w.op    = OP_SCAN;
        w.entry = ENTRY_IDX_W'($urandom_range(255));
        for (k = 0; k < 4; k++) w.ranges[k] = DIST_W'($urandom_range(511));
      end
      send_item(w);
    end
  endtask

  initial begin
    tracker = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // No active entries: a scan compares nothing.
    configure(0, 5, 21, 7, 7);
    send_item(pack_item(OP_SCAN, 255, 0, 0, 0, 0));
    send_item(pack_item(OP_LOAD, 0, 0, 0, 0, 0));
    send_item(pack_item(OP_LOAD, 1, 511, 511, 511, 511));
    send_item(pack_item(OP_LOAD, 2, 511, 0, 511, 0));
    send_item(pack_item(OP_LOAD, 3, 100, 163, 163, 163));
    send_item(pack_item(OP_LOAD, 255, 511, 511, 511, 511));

    // Widest tolerance, no offsets: edges of the tolerance window.
    configure(4, 63, 0, 0, 0);
    send_item(pack_item(OP_SCAN, 0, 0, 0, 0, 0));
    send_item(pack_item(OP_SCAN, 17, 511, 511, 511, 511));
    send_item(pack_item(OP_SCAN, 200, 511, 0, 511, 0));
    send_item(pack_item(OP_SCAN, 1, 62, 0, 0, 0));
    send_item(pack_item(OP_SCAN, 2, 63, 0, 0, 0));

    // Largest offsets push the adjusted distances past the 9-bit range.
    configure(4, 63, 63, 63, 63);
    send_item(pack_item(OP_SCAN, 85, 0, 511, 511, 511));
    send_item(pack_item(OP_SCAN, 170, 511, 448, 448, 448));

    // Zero tolerance matches nothing; a tolerance of one needs exact equality.
    configure(4, 0, 63, 63, 63);
    send_item(pack_item(OP_SCAN, 3, 100, 100, 100, 100));
    configure(4, 1, 63, 63, 63);
    send_item(pack_item(OP_SCAN, 3, 100, 100, 100, 100));

    configure(16, 8, 21, 7, 7);
    fill_table(4);
    random_phase(40, 20, 10, 8);

    // A tight cluster scanned over and over drives the weights into saturation.
    configure(3, 63, 0, 0, 0);
    fill_table(4);
    random_phase(290, 0, 2, 8);

    sender_gap_pct = 62;
    configure(256, 12, 30, 0, 63);
    fill_table(10);
    random_phase(30, 25, 10, 14);

    sender_gap_pct = 0;
    configure(511, 20, 5, 40, 12);
    random_phase(30, 25, 10, 15);
    configure(1, 5, 21, 7, 7);
    random_phase(30, 25, 10, 4);

    drain();
    repeat (10) @(posedge clk);
    if (tracker.failures == 0 && tracker.pending.size() == 0) begin
      $display("[range_fingerprint_matcher] OK");
    end else begin
      if (tracker.pending.size() != 0)
        $display("%0t: %0d result words never came", $time, tracker.pending.size());
      $display("[range_fingerprint_matcher] ERROR");
    end
    $finish;
  end

endmodule
